@@ hw/rtl/epx_pkg.sv @@
// ----------------------------------------------------------------------------
// epx_pkg - equal-power A/B crossfader shared definitions
// Beat types, register indexes, fixed-point widths and the square-root ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package epx_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int ROOT_TABLE_BITS = 10;
	localparam int ROM_SIZE        = (1 << ROOT_TABLE_BITS) + 1;
	localparam int ROM_IDX_BITS    = ROOT_TABLE_BITS + 1;

	// Q16 position and gains, 1.0 = 2^16
	localparam int POS_BITS = 17;
	localparam int CFG_BITS = 17;
	localparam int WIN_BITS = 16;
	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(65536);

	localparam logic [POS_BITS-1:0] RST_SELECT_TARGET = POS_BITS'(32768);
	localparam logic [POS_BITS-1:0] RST_RAMP_STEP     = POS_BITS'(1365);
	localparam logic [WIN_BITS-1:0] RST_METER_WINDOW  = WIN_BITS'(4800);

	typedef enum logic [1:0] {
		REG_SELECT_TARGET = 2'd0,
		REG_RAMP_STEP     = 2'd1,
		REG_METER_WINDOW  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] a_left;
		logic signed [SAMPLE_BITS-1:0] a_right;
		logic signed [SAMPLE_BITS-1:0] b_left;
		logic signed [SAMPLE_BITS-1:0] b_right;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mix_left;
		logic signed [SAMPLE_BITS-1:0] mix_right;
		logic                          meter_valid;
		logic        [SAMPLE_BITS-1:0] peak_a;
		logic        [SAMPLE_BITS-1:0] peak_b;
	} mix_t;

	typedef struct packed {
		logic                   valid;
		logic [SAMPLE_BITS-1:0] peak_a;
		logic [SAMPLE_BITS-1:0] peak_b;
	} meter_t;

	typedef logic [POS_BITS-1:0] root_rom_t [ROM_SIZE];

	// entry k = round(sqrt(k / 2^ROOT_TABLE_BITS) * 2^16), evaluated at elaboration
	function automatic root_rom_t build_root_rom();
		root_rom_t   rom;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		for (int k = 0; k < ROM_SIZE; k++) begin
			x = 64'(k) << (32 - ROOT_TABLE_BITS);
			r = '0;
			b = 64'h1 << 32;
			for (int i = 0; i < 17; i++) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			if (x > r) begin
				r = r + 64'd1;
			end
			rom[k] = r[POS_BITS-1:0];
		end
		return rom;
	endfunction

	localparam root_rom_t ROOT_ROM = build_root_rom();

endpackage

`default_nettype wire

@@ hw/rtl/equal_power_ab_crossfader_unit.sv @@
// ----------------------------------------------------------------------------
// equal_power_ab_crossfader_unit - equal-power A/B crossfader with peak meters
//
//   channel   signals                       direction  content
//   frame     frame_valid/frame_ready/frame in         A and B stereo samples
//   mix       mix_valid/mix_ready/mix       out        mixed stereo + meters
//   config    wr_en/wr_index/wr_data        in         register writes
//
// Three-stage pipeline: gain ROM read, gain products, sum/round/saturate.
// Beats pass s1, s2, s3 to mix_valid; one beat per cycle while mix is not stalled.
// Smoother and meter state update on the input beat itself.
// A stalled output holds its stage; earlier stages keep filling bubbles.
// Reset restores the register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module equal_power_ab_crossfader_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         frame_valid,
	output logic                              frame_ready,
	input  wire epx_pkg::frame_t              frame,
	output logic                              mix_valid,
	input  wire logic                         mix_ready,
	output epx_pkg::mix_t                     mix,
	input  wire logic                         wr_en,
	input  wire logic [1:0]                   wr_index,
	input  wire logic [epx_pkg::CFG_BITS-1:0] wr_data
);

	localparam int SHIFT = 16 - epx_pkg::ROOT_TABLE_BITS;

	logic                             accept;
	logic                             rdy1, rdy2, rdy3;
	logic                             vld_s1, vld_s2, vld_s3;
	logic [epx_pkg::POS_BITS-1:0]     pos_next;
	logic [epx_pkg::POS_BITS-1:0]     pos_inv;
	epx_pkg::meter_t                  meter;
	epx_pkg::frame_t                  frame_s1;
	epx_pkg::meter_t                  meter_s1, meter_s2, meter_s3;
	logic [epx_pkg::POS_BITS-1:0]     ga_s1, gb_s1;
	logic signed [epx_pkg::SAMPLE_BITS-1:0] mix_l, mix_r;

	assign rdy3        = !vld_s3 || mix_ready;
	assign rdy2        = !vld_s2 || rdy3;
	assign rdy1        = !vld_s1 || rdy2;
	assign frame_ready = rdy1;
	assign accept      = frame_valid && rdy1;

	epx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.accept   (accept),
		.a_left   (frame.a_left),
		.b_left   (frame.b_left),
		.pos_next (pos_next),
		.meter    (meter)
	);

	assign pos_inv = epx_pkg::POS_ONE - pos_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= frame_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
		end
	end

	// registered ROM read, indexed by the truncated position
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= frame;
			meter_s1 <= meter;
			ga_s1    <= epx_pkg::ROOT_ROM[pos_inv[epx_pkg::POS_BITS-1:SHIFT]];
			gb_s1    <= epx_pkg::ROOT_ROM[pos_next[epx_pkg::POS_BITS-1:SHIFT]];
		end
		if (rdy2) meter_s2 <= meter_s1;
		if (rdy3) meter_s3 <= meter_s2;
	end

	epx_mix u_mix_l (
		.clk    (clk),
		.en_s2  (rdy2),
		.en_s3  (rdy3),
		.xa     (frame_s1.a_left),
		.xb     (frame_s1.b_left),
		.ga     (ga_s1),
		.gb     (gb_s1),
		.mix_s3 (mix_l)
	);

	epx_mix u_mix_r (
		.clk    (clk),
		.en_s2  (rdy2),
		.en_s3  (rdy3),
		.xa     (frame_s1.a_right),
		.xb     (frame_s1.b_right),
		.ga     (ga_s1),
		.gb     (gb_s1),
		.mix_s3 (mix_r)
	);

	assign mix_valid       = vld_s3;
	assign mix.mix_left    = mix_l;
	assign mix.mix_right   = mix_r;
	assign mix.meter_valid = meter_s3.valid;
	assign mix.peak_a      = meter_s3.peak_a;
	assign mix.peak_b      = meter_s3.peak_b;

`ifndef SYNTHESIS
	ap_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_s1)
		else $error("accepted beat did not reach the first stage");

	ap_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_ready |-> vld_s1 && vld_s2 && vld_s3 && !mix_ready)
		else $error("input stalled while the pipeline has room");

	ap_quiet_meter: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && !mix.meter_valid |-> mix.peak_a == '0 && mix.peak_b == '0)
		else $error("peak fields set without a meter report");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/epx_ctrl.sv @@
// ----------------------------------------------------------------------------
// epx_ctrl - configuration, position smoother and peak meters
// Holds the registers and the per-frame state; updates it on each input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module epx_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [1:0]                          wr_index,
	input  wire logic [epx_pkg::CFG_BITS-1:0]        wr_data,
	input  wire logic                                accept,
	input  wire logic signed [epx_pkg::SAMPLE_BITS-1:0] a_left,
	input  wire logic signed [epx_pkg::SAMPLE_BITS-1:0] b_left,
	output logic [epx_pkg::POS_BITS-1:0]             pos_next,
	output epx_pkg::meter_t                          meter
);

	logic [epx_pkg::POS_BITS-1:0]    select_target_q;
	logic [epx_pkg::POS_BITS-1:0]    ramp_step_q;
	logic [epx_pkg::WIN_BITS-1:0]    meter_window_q;
	logic [epx_pkg::POS_BITS-1:0]    pos_q;
	logic [epx_pkg::WIN_BITS-1:0]    cnt_q;
	logic [epx_pkg::SAMPLE_BITS-1:0] peak_a_q;
	logic [epx_pkg::SAMPLE_BITS-1:0] peak_b_q;

	logic [epx_pkg::POS_BITS-1:0]    target;
	logic [epx_pkg::POS_BITS-1:0]    step;
	logic [epx_pkg::SAMPLE_BITS-1:0] abs_a;
	logic [epx_pkg::SAMPLE_BITS-1:0] abs_b;
	logic [epx_pkg::SAMPLE_BITS-1:0] peak_a_new;
	logic [epx_pkg::SAMPLE_BITS-1:0] peak_b_new;
	logic [epx_pkg::WIN_BITS-1:0]    cnt_inc;
	logic                            close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_target_q <= epx_pkg::RST_SELECT_TARGET;
			ramp_step_q     <= epx_pkg::RST_RAMP_STEP;
			meter_window_q  <= epx_pkg::RST_METER_WINDOW;
		end else if (wr_en) begin
			unique case (epx_pkg::reg_idx_t'(wr_index))
				epx_pkg::REG_SELECT_TARGET: select_target_q <= wr_data;
				epx_pkg::REG_RAMP_STEP:     ramp_step_q     <= wr_data;
				epx_pkg::REG_METER_WINDOW:  meter_window_q  <= wr_data[epx_pkg::WIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// clamp target to 1.0, treat a zero step as one LSB
		target = (select_target_q > epx_pkg::POS_ONE) ? epx_pkg::POS_ONE : select_target_q;
		step   = (ramp_step_q == '0) ? epx_pkg::POS_BITS'(1) : ramp_step_q;
		if (pos_q < target) begin
			pos_next = (target - pos_q <= step) ? target : pos_q + step;
		end else if (pos_q > target) begin
			pos_next = (pos_q - target <= step) ? target : pos_q - step;
		end else begin
			pos_next = pos_q;
		end

		abs_a = a_left[epx_pkg::SAMPLE_BITS-1] ? -a_left : a_left;
		abs_b = b_left[epx_pkg::SAMPLE_BITS-1] ? -b_left : b_left;
		peak_a_new = (abs_a > peak_a_q) ? abs_a : peak_a_q;
		peak_b_new = (abs_b > peak_b_q) ? abs_b : peak_b_q;

		cnt_inc = cnt_q + epx_pkg::WIN_BITS'(1);
		close   = (cnt_inc == meter_window_q);

		meter.valid  = close;
		meter.peak_a = close ? peak_a_new : '0;
		meter.peak_b = close ? peak_b_new : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= epx_pkg::RST_SELECT_TARGET;
			cnt_q    <= '0;
			peak_a_q <= '0;
			peak_b_q <= '0;
		end else if (accept) begin
			pos_q    <= pos_next;
			cnt_q    <= close ? '0 : cnt_inc;
			peak_a_q <= close ? '0 : peak_a_new;
			peak_b_q <= close ? '0 : peak_b_new;
		end
	end

`ifndef SYNTHESIS
	ap_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= epx_pkg::POS_ONE)
		else $error("smoothed position above 1.0");

	ap_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && close |=> cnt_q == '0 && peak_a_q == '0 && peak_b_q == '0)
		else $error("window close did not clear count and peaks");

	ap_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !close |=> cnt_q == $past(cnt_q) + epx_pkg::WIN_BITS'(1))
		else $error("window count did not advance by one");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/epx_mix.sv @@
// ----------------------------------------------------------------------------
// epx_mix - one channel of the equal-power mix
// Registers both gain products, then sums, rounds and saturates the result.
// ----------------------------------------------------------------------------
`default_nettype none

module epx_mix (
	input  wire logic                                   clk,
	input  wire logic                                   en_s2,
	input  wire logic                                   en_s3,
	input  wire logic signed [epx_pkg::SAMPLE_BITS-1:0] xa,
	input  wire logic signed [epx_pkg::SAMPLE_BITS-1:0] xb,
	input  wire logic [epx_pkg::POS_BITS-1:0]           ga,
	input  wire logic [epx_pkg::POS_BITS-1:0]           gb,
	output logic signed [epx_pkg::SAMPLE_BITS-1:0]      mix_s3
);

	localparam int SB        = epx_pkg::SAMPLE_BITS;
	localparam int PROD_BITS = SB + epx_pkg::POS_BITS + 1;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int Q_BITS    = SUM_BITS - 16;

	logic signed [PROD_BITS-1:0] pa_s2;
	logic signed [PROD_BITS-1:0] pb_s2;
	logic signed [SUM_BITS-1:0]  sum;
	logic signed [Q_BITS-1:0]    q;
	logic [Q_BITS-SB:0]          upper;
	logic signed [SB-1:0]        sat;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pa_s2 <= PROD_BITS'(xa) * $signed(PROD_BITS'({1'b0, ga}));
			pb_s2 <= PROD_BITS'(xb) * $signed(PROD_BITS'({1'b0, gb}));
		end
	end

	always_comb begin
		sum   = SUM_BITS'(pa_s2) + SUM_BITS'(pb_s2) + SUM_BITS'(32768);
		q     = Q_BITS'(sum >>> 16);
		upper = q[Q_BITS-1:SB-1];
		// clip when the bits above the sample range disagree with the sign
		if (upper == '0 || upper == '1) begin
			sat = q[SB-1:0];
		end else if (q[Q_BITS-1]) begin
			sat = {1'b1, {(SB-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SB-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mix_s3 <= sat;
		end
	end

endmodule

`default_nettype wire
